FILE: src/zmip_pkg.sv
// Shared types, constants and helpers for the z maximum intensity projection.
// No dependencies; every other file except zmip_ram imports this package.
package zmip_pkg;

    // Size limits of the region
    localparam int MAX_WIDTH    = 512;
    localparam int MAX_HEIGHT   = 512;
    localparam int MAX_CHANNELS = 3;
    localparam int DEPTH_LIMIT  = 4096;

    // Field and register widths
    localparam int BYTE_W     = 8;
    localparam int DIM_W      = 10;
    localparam int DEPTH_W    = 13;
    localparam int CH_W       = 2;
    localparam int INDEX_W    = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Counter and address widths
    localparam int XC_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YC_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int ZC_W  = $clog2(DEPTH_LIMIT);
    localparam int PLANE = MAX_WIDTH * MAX_HEIGHT;
    localparam int PIX_W = (PLANE > 1) ? $clog2(PLANE) : 1;

    // Colour slots of a packed pixel
    localparam int RGB_N = 3;

    // Front-to-back queue
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VOI_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOI_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VOI_DEPTH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BGRA_MODE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_VALUE   = 3'd5;

    // Effective (clamped) configuration
    typedef struct packed {
        logic [DIM_W-1:0]   w;
        logic [DIM_W-1:0]   h;
        logic [DEPTH_W-1:0] d;
        logic [CH_W-1:0]    ch;
        logic               bgra;
        logic [BYTE_W-1:0]  alpha;
    } t_cfg;

    // One classified voxel on its way to the back end
    typedef struct packed {
        logic [BYTE_W-1:0]  voxel;
        logic [CH_W-1:0]    chan;
        logic [PIX_W-1:0]   pix;
        logic               first_z;
        logic               emit;
        logic               bgra;
        logic [INDEX_W-1:0] index;
        logic               last;
    } t_item;

    // Zero acts as one; above the limit saturates
    function automatic logic [DEPTH_W-1:0] clamp_size(input logic [DEPTH_W-1:0] v,
                                                      input logic [DEPTH_W-1:0] hi);
        logic [DEPTH_W-1:0] res;
        if (v == '0) begin
            res = DEPTH_W'(1);
        end else if (v > hi) begin
            res = hi;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

FILE: src/z_max_intensity_projection.sv
// Z maximum intensity projection, top level: configuration registers and
// the front / queue / back pipeline. Depends on zmip_pkg and all zmip_ modules.
//
// Usage:
//  - Input channel (i_in_valid, i_voxel, o_in_stall): one voxel word per
//    accepted cycle, x fastest, then y, then z, then channel.
//  - Output channel (o_out_valid, o_byte0..3, o_pixel_index, o_last,
//    i_out_stall): planar bytes during each channel's last slice, or one
//    BGRA word per pixel during the last channel's last slice.
//  - Configuration (i_cfg_we, i_cfg_index, i_cfg_data): any write, also to an
//    unused index, restarts the raster counters; the stores keep contents.
//    Write only while the pipeline is empty.
//  - Throughput: one voxel word per cycle while o_in_stall is low. Each voxel
//    costs one read of every store and one write of its channel's store; the
//    read is issued as the word enters the execute stage, the write lands as
//    it leaves, and a same-edge collision is served from a bypass register.
//  - Path: a result passes through the queue, then the execute stage, then
//    the output register.
//  - Receiver stall: the output register holds; the execute stage and the
//    two-word queue keep absorbing input until the queue fills, then
//    o_in_stall rises.
//  - Reset: counters to zero, registers to 1,1,1,1,0,255; no store clearing,
//    as the first slice writes every entry before it is read.
module z_max_intensity_projection import zmip_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // voxel input
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [BYTE_W-1:0]     i_voxel,
    // projection output
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [BYTE_W-1:0]     o_byte0,
    output logic [BYTE_W-1:0]     o_byte1,
    output logic [BYTE_W-1:0]     o_byte2,
    output logic [BYTE_W-1:0]     o_byte3,
    output logic [INDEX_W-1:0]    o_pixel_index,
    output logic                  o_last
);

    // raw register values
    logic [DIM_W-1:0]   r_voi_width;
    logic [DIM_W-1:0]   r_voi_height;
    logic [DEPTH_W-1:0] r_voi_depth;
    logic [CH_W-1:0]    r_channel_count;
    logic               r_bgra_mode;
    logic [BYTE_W-1:0]  r_alpha_value;

    t_cfg  cfg;
    t_item front_item;
    t_item head;
    logic  push, pop, q_full, q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voi_width     <= DIM_W'(1);
            r_voi_height    <= DIM_W'(1);
            r_voi_depth     <= DEPTH_W'(1);
            r_channel_count <= CH_W'(1);
            r_bgra_mode     <= 1'b0;
            r_alpha_value   <= BYTE_W'(255);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_VOI_WIDTH:     r_voi_width     <= i_cfg_data[DIM_W-1:0];
                CFG_VOI_HEIGHT:    r_voi_height    <= i_cfg_data[DIM_W-1:0];
                CFG_VOI_DEPTH:     r_voi_depth     <= i_cfg_data[DEPTH_W-1:0];
                CFG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[CH_W-1:0];
                CFG_BGRA_MODE:     r_bgra_mode     <= i_cfg_data[0];
                CFG_ALPHA_VALUE:   r_alpha_value   <= i_cfg_data[BYTE_W-1:0];
                default: ; // unused index: restart only
            endcase
        end
    end

    // sizes of zero act as one, oversize saturates
    always_comb begin
        cfg.w     = DIM_W'(clamp_size(DEPTH_W'(r_voi_width), DEPTH_W'(MAX_WIDTH)));
        cfg.h     = DIM_W'(clamp_size(DEPTH_W'(r_voi_height), DEPTH_W'(MAX_HEIGHT)));
        cfg.d     = clamp_size(r_voi_depth, DEPTH_W'(DEPTH_LIMIT));
        cfg.ch    = CH_W'(clamp_size(DEPTH_W'(r_channel_count), DEPTH_W'(MAX_CHANNELS)));
        cfg.bgra  = r_bgra_mode;
        cfg.alpha = r_alpha_value;
    end

    assign o_in_stall = q_full;

    zmip_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_restart (i_cfg_we),
        .i_valid   (i_in_valid),
        .i_full    (q_full),
        .i_voxel   (i_voxel),
        .o_push    (push),
        .o_item    (front_item)
    );

    zmip_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (head)
    );

    zmip_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_q_valid     (q_valid),
        .i_head        (head),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_byte0       (o_byte0),
        .o_byte1       (o_byte1),
        .o_byte2       (o_byte2),
        .o_byte3       (o_byte3),
        .o_pixel_index (o_pixel_index),
        .o_last        (o_last)
    );

endmodule

FILE: src/zmip_ram.sv
// Generic single-write, single-read RAM with registered read (read-first).
// No dependencies.
module zmip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/zmip_front.sv
// Front end: raster position counters and per-word classification.
// Depends on zmip_pkg.
module zmip_front import zmip_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_restart,
    input  logic  i_valid,
    input  logic  i_full,
    input  logic [BYTE_W-1:0] i_voxel,
    output logic  o_push,
    output t_item o_item
);

    logic [XC_W-1:0]    r_x, n_x;
    logic [YC_W-1:0]    r_y, n_y;
    logic [ZC_W-1:0]    r_z, n_z;
    logic [CH_W-1:0]    r_c, n_c;
    logic [PIX_W-1:0]   r_pix, n_pix;
    logic [INDEX_W-1:0] r_lin, n_lin;
    logic [INDEX_W-1:0] r_base, n_base;

    logic last_x, last_y, last_z, last_c, accept;

    assign last_x = (DIM_W'(r_x) + DIM_W'(1)) >= i_cfg.w;
    assign last_y = (DIM_W'(r_y) + DIM_W'(1)) >= i_cfg.h;
    assign last_z = (DEPTH_W'(r_z) + DEPTH_W'(1)) >= i_cfg.d;
    assign last_c = (r_c + CH_W'(1)) >= i_cfg.ch;
    assign accept = i_valid && !i_full;

    always_comb begin
        o_item.voxel   = i_voxel;
        o_item.chan    = r_c;
        o_item.pix     = r_pix;
        o_item.first_z = (r_z == '0);
        o_item.emit    = last_z && (!i_cfg.bgra || last_c);
        o_item.bgra    = i_cfg.bgra;
        o_item.index   = i_cfg.bgra ? INDEX_W'(r_pix) : r_lin;
        o_item.last    = last_x && last_y && (i_cfg.bgra || last_c);
    end

    assign o_push = accept;

    always_comb begin
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        n_c    = r_c;
        n_pix  = r_pix;
        n_lin  = r_lin;
        n_base = r_base;
        if (accept) begin
            n_pix = r_pix + PIX_W'(1);
            n_lin = r_lin + INDEX_W'(1);
            if (!last_x) begin
                n_x = r_x + XC_W'(1);
            end else begin
                n_x = '0;
                if (!last_y) begin
                    n_y = r_y + YC_W'(1);
                end else begin
                    n_y   = '0;
                    n_pix = '0;
                    if (!last_z) begin
                        // next slice of the same channel: back to channel base
                        n_z   = r_z + ZC_W'(1);
                        n_lin = r_base;
                    end else begin
                        n_z = '0;
                        if (last_c) begin
                            n_c    = '0;
                            n_lin  = '0;
                            n_base = '0;
                        end else begin
                            n_c    = r_c + CH_W'(1);
                            n_base = r_lin + INDEX_W'(1);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_x    <= '0;
            r_y    <= '0;
            r_z    <= '0;
            r_c    <= '0;
            r_pix  <= '0;
            r_lin  <= '0;
            r_base <= '0;
        end else begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_c    <= n_c;
            r_pix  <= n_pix;
            r_lin  <= n_lin;
            r_base <= n_base;
        end
    end

endmodule

FILE: src/zmip_queue.sv
// Short register FIFO between front and back end.
// Depends on zmip_pkg.
module zmip_queue import zmip_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_head
);

    t_item              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr, r_rptr;
    logic [Q_CNT_W-1:0] r_count;

    function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
        logic [Q_PTR_W-1:0] res;
        if (p == Q_PTR_W'(Q_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = p + Q_PTR_W'(1);
        end
        return res;
    endfunction

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= ptr_inc(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= ptr_inc(r_rptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

endmodule

FILE: src/zmip_back.sv
// Back end: per-channel max stores, read-modify-write with bypass, pixel
// packing and the output register. Depends on zmip_pkg and zmip_ram.
module zmip_back import zmip_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_q_valid,
    input  t_item i_head,
    output logic  o_pop,
    output logic  o_out_valid,
    input  logic  i_out_stall,
    output logic [BYTE_W-1:0]  o_byte0,
    output logic [BYTE_W-1:0]  o_byte1,
    output logic [BYTE_W-1:0]  o_byte2,
    output logic [BYTE_W-1:0]  o_byte3,
    output logic [INDEX_W-1:0] o_pixel_index,
    output logic               o_last
);

    // execute stage
    logic              r_b_valid;
    t_item             r_b;
    logic              r_hit;
    logic [CH_W-1:0]   r_hit_chan;
    logic [BYTE_W-1:0] r_byp;

    // output register
    logic               r_out_valid;
    logic [BYTE_W-1:0]  r_byte0, r_byte1, r_byte2, r_byte3;
    logic [INDEX_W-1:0] r_index;
    logic               r_last;

    logic [BYTE_W-1:0] rdata [MAX_CHANNELS];
    logic [BYTE_W-1:0] data  [MAX_CHANNELS];
    logic [BYTE_W-1:0] vals  [RGB_N];
    logic [BYTE_W-1:0] old_v, m;
    logic [BYTE_W-1:0] b_v, g_v, r_v;
    logic              b_leave;

    assign b_leave = r_b_valid && (!r_b.emit || !r_out_valid || !i_out_stall);
    assign o_pop   = i_q_valid && (!r_b_valid || b_leave);

    for (genvar k = 0; k < MAX_CHANNELS; k++) begin : g_store
        zmip_ram #(
            .WIDTH (BYTE_W),
            .DEPTH (PLANE)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (b_leave && (r_b.chan == CH_W'(k))),
            .i_waddr (r_b.pix),
            .i_wdata (m),
            .i_re    (o_pop),
            .i_raddr (i_head.pix),
            .o_rdata (rdata[k])
        );
        // write and read of one address at the same edge: take the new value
        assign data[k] = (r_hit && (r_hit_chan == CH_W'(k))) ? r_byp : rdata[k];
    end

    always_comb begin
        old_v = '0;
        for (int k = 0; k < MAX_CHANNELS; k++) begin
            if (r_b.chan == CH_W'(k)) begin
                old_v = data[k];
            end
        end
    end

    assign m = (r_b.first_z || (r_b.voxel > old_v)) ? r_b.voxel : old_v;

    for (genvar k = 0; k < RGB_N; k++) begin : g_vals
        if (k < MAX_CHANNELS) begin : g_have
            assign vals[k] = (r_b.chan == CH_W'(k)) ? m : data[k];
        end else begin : g_none
            assign vals[k] = '0;
        end
    end

    // blue is the highest channel; one channel is grey
    always_comb begin
        priority if (i_cfg.ch == CH_W'(1)) begin
            b_v = m;
            g_v = m;
            r_v = m;
        end else if (i_cfg.ch == CH_W'(2)) begin
            b_v = '0;
            g_v = vals[1];
            r_v = vals[0];
        end else begin
            b_v = vals[2];
            g_v = vals[1];
            r_v = vals[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_hit     <= 1'b0;
        end else begin
            if (o_pop) begin
                r_b_valid <= 1'b1;
                r_hit     <= b_leave && (r_b.pix == i_head.pix);
            end else if (b_leave) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b        <= i_head;
            r_hit_chan <= r_b.chan;
            r_byp      <= m;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (b_leave && r_b.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_leave && r_b.emit) begin
            if (r_b.bgra) begin
                r_byte0 <= b_v;
                r_byte1 <= g_v;
                r_byte2 <= r_v;
                r_byte3 <= i_cfg.alpha;
            end else begin
                r_byte0 <= m;
                r_byte1 <= '0;
                r_byte2 <= '0;
                r_byte3 <= '0;
            end
            r_index <= r_b.index;
            r_last  <= r_b.last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_byte0       = r_byte0;
    assign o_byte1       = r_byte1;
    assign o_byte2       = r_byte2;
    assign o_byte3       = r_byte3;
    assign o_pixel_index = r_index;
    assign o_last        = r_last;

endmodule

FILE: tb/sv/tb_z_max_intensity_projection.sv
`timescale 1ns / 1ps
// Self-checking testbench for z_max_intensity_projection: a scoreboard class
// predicts every projected word from the voxel stream. Depends on zmip_pkg and the RTL.
module tb_z_max_intensity_projection;
    import zmip_pkg::*;

    // Restart-only register indexes, beyond the real register list
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    // Cycles the pipeline may still hold words that give no result
    localparam int DRAIN_CYCLES = 8;
    // Cycles without any handshake before the run is declared hung
    localparam int QUIET_LIMIT  = 2000;
    // Random voxel words after the directed and boundary parts
    localparam int RANDOM_WORDS = 450;
    // Voxels sent into each of the larger boundary regions
    localparam int EDGE_WORDS   = 64;

    typedef struct packed {
        logic [BYTE_W-1:0]  b0;
        logic [BYTE_W-1:0]  b1;
        logic [BYTE_W-1:0]  b2;
        logic [BYTE_W-1:0]  b3;
        logic [INDEX_W-1:0] index;
        logic               last;
    } t_proj_result;

    // Projection predictor plus the queue of projected words still awaited
    class projection_scoreboard;
        logic [DIM_W-1:0]   reg_w;
        logic [DIM_W-1:0]   reg_h;
        logic [DEPTH_W-1:0] reg_d;
        logic [CH_W-1:0]    reg_c;
        logic               reg_bgra;
        logic [BYTE_W-1:0]  reg_alpha;
        int unsigned        col, row, slice, chan;
        logic [BYTE_W-1:0]  peak [int unsigned];
        t_proj_result       awaited [$];
        int unsigned        errors;

        function void clear();
            reg_w     = 1;
            reg_h     = 1;
            reg_d     = 1;
            reg_c     = 1;
            reg_bgra  = 1'b0;
            reg_alpha = 8'hFF;
            col = 0; row = 0; slice = 0; chan = 0;
            peak.delete();
            awaited.delete();
            errors = 0;
        endfunction

        // zero means one, anything above the limit saturates
        function int unsigned fit(input int unsigned v, input int unsigned hi);
            if (v == 0) return 1;
            return (v > hi) ? hi : v;
        endfunction

        function int unsigned volume();
            return fit(reg_w, MAX_WIDTH) * fit(reg_h, MAX_HEIGHT) *
                   fit(reg_d, DEPTH_LIMIT) * fit(reg_c, MAX_CHANNELS);
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function logic [BYTE_W-1:0] peek(input int unsigned addr);
            return peak.exists(addr) ? peak[addr] : '0;
        endfunction

        function void note_config(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_VOI_WIDTH:     reg_w     = data[DIM_W-1:0];
                CFG_VOI_HEIGHT:    reg_h     = data[DIM_W-1:0];
                CFG_VOI_DEPTH:     reg_d     = data[DEPTH_W-1:0];
                CFG_CHANNEL_COUNT: reg_c     = data[CH_W-1:0];
                CFG_BGRA_MODE:     reg_bgra  = data[0];
                CFG_ALPHA_VALUE:   reg_alpha = data[BYTE_W-1:0];
                default: ;
            endcase
            // every write restarts the raster, the store is left alone
            col = 0; row = 0; slice = 0; chan = 0;
        endfunction

        function void note_voxel(input logic [BYTE_W-1:0] v);
            int unsigned  w, h, d, nc, plane, pix, addr;
            logic [BYTE_W-1:0] m;
            bit           lx, ly, lz, lc;
            t_proj_result r;
            w     = fit(reg_w, MAX_WIDTH);
            h     = fit(reg_h, MAX_HEIGHT);
            d     = fit(reg_d, DEPTH_LIMIT);
            nc    = fit(reg_c, MAX_CHANNELS);
            plane = w * h;
            pix   = row * w + col;
            addr  = chan * plane + pix;
            lx    = (col + 1 >= w);
            ly    = (row + 1 >= h);
            lz    = (slice + 1 >= d);
            lc    = (chan + 1 >= nc);
            // first slice overwrites, later slices keep the larger byte
            if (slice == 0) m = v;
            else m = (v > peek(addr)) ? v : peek(addr);
            peak[addr] = m;
            if (lz && !reg_bgra) begin
                r.b0    = m;
                r.b1    = '0;
                r.b2    = '0;
                r.b3    = '0;
                r.index = INDEX_W'(addr);
                r.last  = lx && ly && lc;
                awaited.push_back(r);
            end else if (lz && lc) begin
                if (nc == 1) begin
                    r.b0 = m;
                    r.b1 = m;
                    r.b2 = m;
                end else begin
                    // two channels leave blue at zero
                    r.b2 = peek(pix);
                    r.b1 = peek(plane + pix);
                    r.b0 = (nc >= 3) ? peek(2 * plane + pix) : '0;
                end
                r.b3    = reg_alpha;
                r.index = INDEX_W'(pix);
                r.last  = lx && ly;
                awaited.push_back(r);
            end
            if (!lx) begin
                col++;
            end else begin
                col = 0;
                if (!ly) begin
                    row++;
                end else begin
                    row = 0;
                    if (!lz) begin
                        slice++;
                    end else begin
                        slice = 0;
                        chan  = lc ? 0 : chan + 1;
                    end
                end
            end
        endfunction

        task report(input string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        task check(input t_proj_result got);
            t_proj_result want;
            if (awaited.size() == 0) begin
                report($sformatf("unexpected word at index %0d", got.index));
            end else begin
                want = awaited.pop_front();
                if (got.b0 !== want.b0)
                    report($sformatf("byte0 got %0h want %0h", got.b0, want.b0));
                if (got.b1 !== want.b1)
                    report($sformatf("byte1 got %0h want %0h", got.b1, want.b1));
                if (got.b2 !== want.b2)
                    report($sformatf("byte2 got %0h want %0h", got.b2, want.b2));
                if (got.b3 !== want.b3)
                    report($sformatf("byte3 got %0h want %0h", got.b3, want.b3));
                if (got.index !== want.index)
                    report($sformatf("pixel_index got %0d want %0d",
                                     got.index, want.index));
                if (got.last !== want.last)
                    report($sformatf("last got %0b want %0b at index %0d",
                                     got.last, want.last, want.index));
            end
        endtask
    endclass

    // Block-facing signals; the ones the bench drives are known from time zero
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  in_valid    = 1'b0;
    logic [BYTE_W-1:0]     in_voxel    = '0;
    logic                  out_stall   = 1'b0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [BYTE_W-1:0]     o_byte0, o_byte1, o_byte2, o_byte3;
    logic [INDEX_W-1:0]    o_pixel_index;
    logic                  o_last;

    projection_scoreboard sb;
    bit                   no_gaps    = 1'b0;   // burst stretches: neither side idles
    int unsigned          rx_gap     = 0;      // stall cycles left before the next word
    int unsigned          words_sent = 0;
    int unsigned          quiet      = 0;

    z_max_intensity_projection u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (o_in_stall),
        .i_voxel       (in_voxel),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (out_stall),
        .o_byte0       (o_byte0),
        .o_byte1       (o_byte1),
        .o_byte2       (o_byte2),
        .o_byte3       (o_byte3),
        .o_pixel_index (o_pixel_index),
        .o_last        (o_last)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Receiver: after each accepted word, stall for a freshly drawn count
    always @(negedge i_clk) begin
        out_stall = (rx_gap != 0);
        if (rx_gap != 0) rx_gap--;
    end

    // Output monitor, sampled at the rising edge
    always @(posedge i_clk) begin
        t_proj_result got;
        if (i_rst_n && o_out_valid && !out_stall) begin
            got.b0    = o_byte0;
            got.b1    = o_byte1;
            got.b2    = o_byte2;
            got.b3    = o_byte3;
            got.index = o_pixel_index;
            got.last  = o_last;
            sb.check(got);
            rx_gap = no_gaps ? 0 : $urandom_range(0, 9);
        end
    end

    // Watchdog: any handshake or register write counts as progress
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall) || cfg_we)
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("tb_z_max_intensity_projection: FAIL");
            $finish;
        end
    end

    // Sender: idle for a drawn count, then hold the word until it is taken.
    // Valid is left high after acceptance; the next call either lowers it
    // or puts the next word straight on the bus.
    task automatic send_voxel(input logic [BYTE_W-1:0] v);
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            @(negedge i_clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_valid = 1'b1;
        in_voxel = v;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_voxel(v);
        words_sent++;
    endtask

    // Stop sending and let every awaited word and the pipeline tail drain
    task automatic settle();
        @(negedge i_clk);
        in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge i_clk);
        sb.note_config(idx, data);
    endtask

    task automatic end_writes();
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                              input logic [CFG_DATA_W-1:0] d, input logic [CFG_DATA_W-1:0] c,
                              input logic [CFG_DATA_W-1:0] bgra,
                              input logic [CFG_DATA_W-1:0] alpha);
        settle();
        write_reg(CFG_VOI_WIDTH, w);
        write_reg(CFG_VOI_HEIGHT, h);
        write_reg(CFG_VOI_DEPTH, d);
        write_reg(CFG_CHANNEL_COUNT, c);
        write_reg(CFG_BGRA_MODE, bgra);
        write_reg(CFG_ALPHA_VALUE, alpha);
        end_writes();
    endtask

    // Bias towards the byte extremes so ties and saturating maxima turn up
    function automatic logic [BYTE_W-1:0] pick_voxel();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Random words; at word hold_at the sender waits for all results
    task automatic send_run(input int unsigned count, input int hold_at);
        for (int i = 0; i < count; i++) begin
            if (i == hold_at) settle();
            send_voxel(pick_voxel());
        end
    endtask

    // One random setting: small region, junk in the unused data bits,
    // whole volumes of random content, now and then a volume cut short
    task automatic random_phase(input bit first);
        int unsigned vol;
        int          hold_at;
        no_gaps = ($urandom_range(0, 3) == 0);
        set_config(CFG_DATA_W'($urandom_range(0, 5)) | CFG_DATA_W'($urandom_range(0, 7) << DIM_W),
                   CFG_DATA_W'($urandom_range(0, 5)) | CFG_DATA_W'($urandom_range(0, 7) << DIM_W),
                   CFG_DATA_W'($urandom_range(0, 4)),
                   CFG_DATA_W'($urandom_range(0, 3)) |
                       CFG_DATA_W'($urandom_range(0, 2047) << CH_W),
                   CFG_DATA_W'($urandom_range(0, 8191)),
                   CFG_DATA_W'($urandom_range(0, 8191)));
        if ($urandom_range(0, 3) == 0) begin
            write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO,
                      CFG_DATA_W'($urandom_range(0, 8191)));
            end_writes();
        end
        vol     = sb.volume();
        hold_at = -1;
        if (first) hold_at = vol / 2;
        else if ($urandom_range(0, 7) == 0) hold_at = $urandom_range(0, vol - 1);
        send_run(vol * $urandom_range(1, 3), hold_at);
        if (vol > 1 && $urandom_range(0, 3) == 0)
            send_run($urandom_range(1, vol - 1), -1);
    endtask

    initial begin
        int unsigned random_goal;
        sb = new();
        sb.clear();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings: one voxel per volume, so every word wraps the raster
        send_voxel(8'h00); send_voxel(8'hFF); send_voxel(8'hAA); send_voxel(8'h55);

        // Zero width and zero channels act as one; maximum over three slices
        set_config(13'h0000, 13'd2, 13'd3, 13'h0000, 13'd0, 13'h0000);
        send_voxel(8'd9);   send_voxel(8'd200);
        send_voxel(8'd255); send_voxel(8'd0);
        send_voxel(8'd100); send_voxel(8'd100);

        // Two channels packed: blue stays zero, alpha at its low extreme
        set_config(13'd2, 13'd1, 13'd1, 13'd2, 13'd1, 13'h0000);
        send_voxel(8'h11); send_voxel(8'hFE); send_voxel(8'h22); send_voxel(8'h01);

        // Three channels packed, swapped to B,G,R
        set_config(13'd2, 13'd1, 13'd1, 13'd3, 13'd1, 13'h00FF);
        send_voxel(8'h10); send_voxel(8'h20); send_voxel(8'h30);
        send_voxel(8'h40); send_voxel(8'h50); send_voxel(8'h60);

        // Grey packed: one channel copied to all three colours
        set_config(13'd2, 13'd1, 13'd2, 13'd1, 13'd1, 13'h005A);
        send_voxel(8'h80); send_voxel(8'h7F); send_voxel(8'h81); send_voxel(8'h7E);

        // Writes to unused indexes restart a half-done projection
        set_config(13'd2, 13'd2, 13'd1, 13'd1, 13'd0, 13'h00FF);
        send_voxel(8'h33); send_voxel(8'h44);
        settle();
        write_reg(CFG_SPARE_LO, 13'h1FFF);
        end_writes();
        send_voxel(8'h01); send_voxel(8'h02); send_voxel(8'h03); send_voxel(8'h04);
        send_voxel(8'hC3);
        settle();
        write_reg(CFG_SPARE_HI, 13'h0000);
        end_writes();
        send_voxel(8'h3C);

        // Boundary sizes: a whole saturated row, then the start of a tall
        // three-channel region and of the deepest stack in grey BGRA
        set_config(13'h1FFF, 13'd1, 13'd1, 13'd1, 13'd0, 13'h0000);
        send_run(sb.volume(), -1);
        set_config(13'd1, 13'h03FF, 13'd1, 13'd3, 13'd0, 13'h00FF);
        send_run(EDGE_WORDS, -1);
        set_config(13'd1, 13'd1, 13'h1FFF, 13'd1, 13'd1, 13'h0080);
        send_run(EDGE_WORDS, -1);

        // Random settings; the first one holds off until all results are in
        random_goal = words_sent + RANDOM_WORDS;
        random_phase(1'b1);
        while (words_sent < random_goal) random_phase(1'b0);

        no_gaps = 1'b0;
        settle();
        if (sb.pending() != 0)
            sb.report($sformatf("%0d projected words never arrived", sb.pending()));
        if (sb.errors == 0) begin
            $display("tb_z_max_intensity_projection: PASS");
        end else begin
            $display("tb_z_max_intensity_projection: FAIL");
        end
        $finish;
    end

endmodule
